@@ hdl/tcphop_pkg.sv @@
// ----------------------------------------------------------------------------
// tcphop_pkg
// Shared types and codes of the TCP header and option parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcphop_pkg;

	// record type codes
	localparam logic [2:0] REC_HEADER    = 3'd0;
	localparam logic [2:0] REC_OPT_START = 3'd1;
	localparam logic [2:0] REC_OPT_BYTE  = 3'd2;
	localparam logic [2:0] REC_TRUNCATED = 3'd3;
	localparam logic [2:0] REC_OFF_SMALL = 3'd4;
	localparam logic [2:0] REC_OUTSIDE   = 3'd5;
	localparam logic [2:0] REC_MALFORMED = 3'd6;

	// option walk phases
	localparam logic [1:0] PH_KIND = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	localparam logic [5:0] POS_HDR_LAST = 6'd19;
	localparam logic [5:0] POS_OPT_BASE = 6'd20;
	localparam logic [5:0] POS_MAX      = 6'd63;
	localparam logic [5:0] MIN_HDR_LEN  = 6'd20;

	localparam int QueueDepthDef = 4;
	localparam int OutDataBytes  = 21;

	typedef struct packed {
		logic [15:0] checksum;
		logic [15:0] window;
		logic [7:0]  flags;
		logic [31:0] ack;
		logic [31:0] seq;
		logic [15:0] dst;
		logic [15:0] src;
	} hdr_t;

	// queue entry: one per accepted word that gives records
	typedef struct packed {
		hdr_t       hdr;
		logic       prim_valid;
		logic [2:0] prim_type;
		logic       prim_hdr;
		logic [5:0] prim_hb;
		logic [7:0] prim_kind;
		logic [7:0] prim_value;
		logic       tail_valid;
		logic [2:0] tail_type;
		logic [5:0] tail_hb;
	} entry_t;

	// output record, record_type in the lowest bits
	typedef struct packed {
		logic [7:0]  value;
		logic [7:0]  kind;
		logic [15:0] checksum;
		logic [15:0] window;
		logic [7:0]  flags;
		logic [5:0]  hb;
		logic [31:0] ack;
		logic [31:0] seq;
		logic [15:0] dst;
		logic [15:0] src;
		logic [2:0]  rtype;
	} rec_t;

endpackage

`default_nettype wire

@@ hdl/tcphop_fifo.sv @@
// ----------------------------------------------------------------------------
// tcphop_fifo
// Small register queue between the parse front and the record back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcphop_fifo #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [Width-1:0]      head_data
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/tcphop_front.sv @@
// ----------------------------------------------------------------------------
// tcphop_front
// Byte position tracking, header capture and option walk; builds queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcphop_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       seg_byte,
	input  wire logic             sos,
	input  wire logic             eos,
	output logic                  push,
	output tcphop_pkg::entry_t    entry
);

	import tcphop_pkg::*;

	logic [5:0]  pos_q;
	logic [15:0] src_q, dst_q, window_q, checksum_q;
	logic [31:0] seq_q, ack_q;
	logic [3:0]  off_q;
	logic [7:0]  flags_q;
	logic [1:0]  phase_q;
	logic [7:0]  kind_q;
	logic [5:0]  left_q;
	logic        stop_q;

	logic [5:0]  p;
	logic [1:0]  ph_e, ph_n;
	logic [7:0]  kind_e, kind_n;
	logic [5:0]  left_e, left_n, left_dec;
	logic        stop_e, stop_n;
	logic [3:0]  off_n;
	logic [5:0]  hb;
	logic        walk;
	logic [8:0]  len_end;
	logic [6:0]  p_inc;

	assign p       = sos ? '0 : pos_q;
	assign ph_e    = sos ? PH_KIND : phase_q;
	assign kind_e  = sos ? '0 : kind_q;
	assign left_e  = sos ? '0 : left_q;
	assign stop_e  = sos ? 1'b0 : stop_q;
	assign off_n   = (p == 6'd12) ? seg_byte[7:4] : off_q;
	assign hb      = {off_n, 2'b00};
	assign p_inc   = {1'b0, p} + 7'd1;
	assign len_end = {3'b000, p} - 9'd1 + {1'b0, seg_byte};
	assign walk    = (p >= POS_OPT_BASE) && (hb > MIN_HDR_LEN) && (p < hb) && !stop_e;
	assign left_dec = (left_e != '0) ? left_e - 1'b1 : left_e;

	always_comb begin
		entry            = '0;
		entry.hdr.src      = src_q;
		entry.hdr.dst      = dst_q;
		entry.hdr.seq      = seq_q;
		entry.hdr.ack      = ack_q;
		entry.hdr.flags    = flags_q;
		entry.hdr.window   = window_q;
		entry.hdr.checksum = checksum_q;
		ph_n   = ph_e;
		kind_n = kind_e;
		left_n = left_e;
		stop_n = stop_e;

		if (p == POS_HDR_LAST) begin
			entry.prim_valid = 1'b1;
			entry.prim_type  = REC_HEADER;
			entry.prim_hdr   = 1'b1;
			entry.prim_hb    = hb;
		end else if (walk) begin
			unique case (ph_e)
				PH_KIND: begin
					if (seg_byte <= 8'd1) begin
						entry.prim_valid = 1'b1;
						entry.prim_type  = REC_OPT_START;
						entry.prim_kind  = seg_byte;
					end else if (p_inc >= {1'b0, hb}) begin
						entry.prim_valid = 1'b1;
						entry.prim_type  = REC_MALFORMED;
						entry.prim_kind  = seg_byte;
						stop_n = 1'b1;
					end else begin
						kind_n = seg_byte;
						ph_n   = PH_LEN;
					end
				end
				PH_LEN: begin
					entry.prim_valid = 1'b1;
					entry.prim_kind  = kind_e;
					entry.prim_value = seg_byte;
					if (seg_byte < 8'd2 || len_end > {3'b000, hb}) begin
						entry.prim_type = REC_MALFORMED;
						stop_n = 1'b1;
						ph_n   = PH_KIND;
					end else begin
						entry.prim_type = REC_OPT_START;
						if (seg_byte == 8'd2) begin
							ph_n = PH_KIND;
						end else begin
							left_n = 6'(seg_byte - 8'd2);
							ph_n   = PH_DATA;
						end
					end
				end
				default: begin
					entry.prim_valid = 1'b1;
					entry.prim_type  = REC_OPT_BYTE;
					entry.prim_kind  = kind_e;
					entry.prim_value = seg_byte;
					left_n = left_dec;
					if (left_dec == '0) begin
						ph_n = PH_KIND;
					end
				end
			endcase
		end

		priority if (p == POS_HDR_LAST && hb < MIN_HDR_LEN) begin
			entry.tail_valid = 1'b1;
			entry.tail_type  = REC_OFF_SMALL;
			entry.tail_hb    = hb;
		end else if (eos && p < POS_HDR_LAST) begin
			entry.tail_valid = 1'b1;
			entry.tail_type  = REC_TRUNCATED;
		end else if (eos && hb >= MIN_HDR_LEN && p_inc < {1'b0, hb}) begin
			entry.tail_valid = 1'b1;
			entry.tail_type  = REC_OUTSIDE;
			entry.tail_hb    = hb;
		end else begin
			entry.tail_valid = 1'b0;
		end

		// segment end restarts the walk
		if (eos) begin
			ph_n   = PH_KIND;
			kind_n = '0;
			left_n = '0;
			stop_n = 1'b0;
		end
	end

	assign push = accept && (entry.prim_valid || entry.tail_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			seq_q      <= '0;
			ack_q      <= '0;
			off_q      <= '0;
			flags_q    <= '0;
			window_q   <= '0;
			checksum_q <= '0;
			phase_q    <= PH_KIND;
			kind_q     <= '0;
			left_q     <= '0;
			stop_q     <= 1'b0;
		end else if (accept) begin
			unique case (p)
				6'd0:  src_q <= {seg_byte, 8'h00};
				6'd1:  src_q <= {src_q[15:8], seg_byte};
				6'd2:  dst_q <= {seg_byte, 8'h00};
				6'd3:  dst_q <= {dst_q[15:8], seg_byte};
				6'd4, 6'd5, 6'd6, 6'd7:  seq_q <= {seq_q[23:0], seg_byte};
				6'd8, 6'd9, 6'd10, 6'd11: ack_q <= {ack_q[23:0], seg_byte};
				6'd13: flags_q <= seg_byte;
				6'd14: window_q <= {seg_byte, 8'h00};
				6'd15: window_q <= {window_q[15:8], seg_byte};
				6'd16: checksum_q <= {seg_byte, 8'h00};
				6'd17: checksum_q <= {checksum_q[15:8], seg_byte};
				default: ;
			endcase
			off_q   <= off_n;
			phase_q <= ph_n;
			kind_q  <= kind_n;
			left_q  <= left_n;
			stop_q  <= stop_n;
			if (eos) begin
				pos_q <= '0;
			end else begin
				pos_q <= (p < POS_MAX) ? p + 1'b1 : POS_MAX;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/tcphop_back.sv @@
// ----------------------------------------------------------------------------
// tcphop_back
// Unpacks queue entries into records, one record a cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcphop_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               not_empty,
	input  wire tcphop_pkg::entry_t head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tcphop_pkg::rec_t        out_rec,
	output logic                    out_last
);

	import tcphop_pkg::*;

	logic  out_valid_q;
	rec_t  out_rec_q;
	logic  out_last_q;
	logic  tail_next_q;   // primary of head already sent
	logic  load;
	logic  take_prim;
	rec_t  rec_n;

	assign load      = !out_valid_q || out_ready;
	assign take_prim = head.prim_valid && !tail_next_q;
	assign pop       = load && not_empty && !(take_prim && head.tail_valid);

	always_comb begin
		rec_n = '0;
		if (take_prim) begin
			rec_n.rtype = head.prim_type;
			rec_n.hb    = head.prim_hb;
			rec_n.kind  = head.prim_kind;
			rec_n.value = head.prim_value;
			if (head.prim_hdr) begin
				rec_n.src      = head.hdr.src;
				rec_n.dst      = head.hdr.dst;
				rec_n.seq      = head.hdr.seq;
				rec_n.ack      = head.hdr.ack;
				rec_n.flags    = head.hdr.flags;
				rec_n.window   = head.hdr.window;
				rec_n.checksum = head.hdr.checksum;
			end
		end else begin
			rec_n.rtype = head.tail_type;
			rec_n.hb    = head.tail_hb;
		end
	end

	always_ff @(posedge clk) begin
		if (load && not_empty) begin
			out_rec_q  <= rec_n;
			out_last_q <= !(take_prim && head.tail_valid);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tail_next_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= not_empty;
			if (not_empty) begin
				tail_next_q <= take_prim && head.tail_valid;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

@@ hdl/tcp_header_option_parser.sv @@
// ----------------------------------------------------------------------------
// tcp_header_option_parser
// Parses TCP header fields and options from a byte stream into records.
// ----------------------------------------------------------------------------
//  channel  dir  fields (tdata/tuser/tlast)
//  s_axis   in   seg_byte / start_of_segment / end_of_segment
//  m_axis   out  record fields (record_type lowest) / - / last_of_run
//
//  One input word is taken per cycle while the entry queue has room; the front
//  classifies it in the cycle it is accepted.
//  Each word gives zero, one or two records (header plus offset-small, or a
//  header or option record plus outside); the back end sends one record a cycle
//  while the output is not stalled, and the queue absorbs the surplus.
//  Output stalls fill the queue (QUEUE_DEPTH entries); the queue full flag then drops
//  s_axis_tready. No clearing pass: s_axis_tready is high from reset onward.
//  Reset is asynchronous, active low; parse state returns to byte 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcp_header_option_parser #(
	parameter int QUEUE_DEPTH = tcphop_pkg::QueueDepthDef
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // [7:0] seg_byte
	input  wire logic         s_axis_tuser,   // [0] start_of_segment
	input  wire logic         s_axis_tlast,   // end_of_segment
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [2:0] record_type, [18:3] src_port, [34:19] dst_port, [66:35] seq_number,
	// [98:67] ack_number, [104:99] header_bytes, [112:105] flag_bits,
	// [128:113] window_size, [144:129] header_checksum, [152:145] option_kind,
	// [160:153] option_value, [167:161] zero
	output logic [tcphop_pkg::OutDataBytes*8-1:0] m_axis_tdata,
	output logic              m_axis_tlast    // last_of_run
);

	import tcphop_pkg::*;

	localparam int EntryW = $bits(entry_t);
	localparam int RecW   = $bits(rec_t);

	logic              accept;
	logic              push;
	entry_t            push_entry;
	logic              q_full;
	logic              q_not_empty;
	logic [EntryW-1:0] head_bits;
	entry_t            head;
	logic              pop;
	rec_t              out_rec;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// front: position, header capture, option walk
	tcphop_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.seg_byte (s_axis_tdata),
		.sos      (s_axis_tuser),
		.eos      (s_axis_tlast),
		.push     (push),
		.entry    (push_entry)
	);

	// decouples word intake from record output
	tcphop_fifo #(
		.Width (EntryW),
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head_data (head_bits)
	);

	assign head = entry_t'(head_bits);

	// back: one record per cycle into the output register while the output is not stalled
	tcphop_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rec   (out_rec),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {(OutDataBytes * 8 - RecW)'(0), out_rec};

endmodule

`default_nettype wire

@@ tb/tcp_header_option_parser_tb.sv @@
// ----------------------------------------------------------------------------
// tcp_header_option_parser_tb
// Self-checking bench for the TCP header and option parser. Whole segments are
// streamed in as bytes and each byte is run through a parse model kept in a
// scoreboard. Every record that comes out is checked, field by field, against
// the oldest record still owed. Both stream sides idle at random. One long
// output stall backs the block up until it stops taking input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_header_option_parser_tb;
	import tcphop_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_WORDS  = 900;
	localparam int DRAIN_CYCLES  = 20;
	localparam int LONG_STALL    = 300;
	localparam int STALL_AT_WORD = 250;
	localparam int CALM_FROM     = 400;
	localparam int CALM_TO       = 560;

	// one owed record plus its last_of_run bit
	typedef struct packed {
		rec_t rec;
		logic last;
	} owed_rec_t;

	// ------------------------------------------------------------------------
	// Scoreboard: parses each accepted byte on its own copy of the parse state
	// and queues the records that byte must produce.
	// ------------------------------------------------------------------------
	class tcp_record_scoreboard;
		owed_rec_t  owed[$];
		int         errors;
		int         words;
		int         checked;
		int         seen_by_type[8];

		logic [5:0]  pos;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [3:0]  off_words;
		logic [7:0]  flags;
		logic [15:0] window;
		logic [15:0] csum;
		logic [1:0]  phase;
		logic [7:0]  cur_kind;
		logic [5:0]  bytes_left;
		logic        walk_stopped;

		function new();
			pos = '0;
			src_port = '0;
			dst_port = '0;
			seq_num = '0;
			ack_num = '0;
			off_words = '0;
			flags = '0;
			window = '0;
			csum = '0;
			restart_walk();
		endfunction

		function void restart_walk();
			phase = PH_KIND;
			cur_kind = '0;
			bytes_left = '0;
			walk_stopped = 1'b0;
		endfunction

		task report(string what);
			$display("%0t ns  mismatch: %s", $time, what);
			errors++;
		endtask

		function int pending();
			return owed.size();
		endfunction

		function void owe(logic [2:0] rtype, logic [7:0] kind, logic [7:0] value,
				logic [5:0] hb, bit with_hdr);
			owed_rec_t o;
			o = '0;
			o.rec.rtype = rtype;
			o.rec.kind = kind;
			o.rec.value = value;
			o.rec.hb = hb;
			if (with_hdr) begin
				o.rec.src = src_port;
				o.rec.dst = dst_port;
				o.rec.seq = seq_num;
				o.rec.ack = ack_num;
				o.rec.flags = flags;
				o.rec.window = window;
				o.rec.checksum = csum;
			end
			owed = {owed, o};
		endfunction

		// parse one accepted word
		function void note_word(logic [7:0] b, logic sos, logic eos);
			int         p;
			int         hb;
			int         owed_at_start;
			logic [5:0] hb6;
			owed_at_start = owed.size();
			words++;
			if (sos) begin
				pos = '0;
				restart_walk();
			end
			p = pos;

			// header capture, network order
			case (p)
				0:  src_port = {b, 8'h00};
				1:  src_port[7:0] = b;
				2:  dst_port = {b, 8'h00};
				3:  dst_port[7:0] = b;
				4, 5, 6, 7:    seq_num = {seq_num[23:0], b};
				8, 9, 10, 11:  ack_num = {ack_num[23:0], b};
				12: off_words = b[7:4];
				13: flags = b;
				14: window = {b, 8'h00};
				15: window[7:0] = b;
				16: csum = {b, 8'h00};
				17: csum[7:0] = b;
				default: ;
			endcase
			hb6 = {off_words, 2'b00};
			hb = hb6;

			if (p == POS_HDR_LAST) begin
				owe(REC_HEADER, 8'h00, 8'h00, hb6, 1'b1);
				if (hb < MIN_HDR_LEN)
					owe(REC_OFF_SMALL, 8'h00, 8'h00, hb6, 1'b0);
			end else if (p >= POS_OPT_BASE && hb > MIN_HDR_LEN && p < hb && !walk_stopped) begin
				case (phase)
					PH_KIND: begin
						if (b <= 8'd1) begin
							// end-of-list and no-op stand alone
							owe(REC_OPT_START, b, 8'h00, 6'd0, 1'b0);
						end else if (p + 1 >= hb) begin
							// kind with no room left for its length byte
							owe(REC_MALFORMED, b, 8'h00, 6'd0, 1'b0);
							walk_stopped = 1'b1;
						end else begin
							cur_kind = b;
							phase = PH_LEN;
						end
					end
					PH_LEN: begin
						if (b < 8'd2 || (p - 1) + int'(b) > hb) begin
							owe(REC_MALFORMED, cur_kind, b, 6'd0, 1'b0);
							walk_stopped = 1'b1;
							phase = PH_KIND;
						end else begin
							owe(REC_OPT_START, cur_kind, b, 6'd0, 1'b0);
							if (b == 8'd2) begin
								phase = PH_KIND;
							end else begin
								bytes_left = 6'(b - 8'd2);
								phase = PH_DATA;
							end
						end
					end
					default: begin
						owe(REC_OPT_BYTE, cur_kind, b, 6'd0, 1'b0);
						if (bytes_left != 0)
							bytes_left--;
						if (bytes_left == 0)
							phase = PH_KIND;
					end
				endcase
			end

			if (eos) begin
				if (p < POS_HDR_LAST)
					owe(REC_TRUNCATED, 8'h00, 8'h00, 6'd0, 1'b0);
				else if (hb >= MIN_HDR_LEN && p + 1 < hb)
					owe(REC_OUTSIDE, 8'h00, 8'h00, hb6, 1'b0);
				pos = '0;
				restart_walk();
			end else begin
				pos = (p < POS_MAX) ? 6'(p + 1) : POS_MAX;
			end

			if (owed.size() > owed_at_start)
				owed[owed.size() - 1].last = 1'b1;
		endfunction

		task check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("record %0d %s got 0x%0h want 0x%0h", checked, name,
						got, want));
		endtask

		// compare one accepted record with the oldest owed one
		task check_record(logic [OutDataBytes*8-1:0] data, logic last);
			rec_t      got;
			owed_rec_t want;
			got = rec_t'(data[$bits(rec_t)-1:0]);
			if (got.rtype <= REC_MALFORMED)
				seen_by_type[got.rtype]++;
			if (data[OutDataBytes*8-1:$bits(rec_t)] !== '0)
				report($sformatf("record %0d has nonzero padding", checked));
			if (owed.size() == 0) begin
				report($sformatf("unexpected record, type %0d", got.rtype));
			end else begin
				want = owed.pop_front();
				check_field("record_type", got.rtype, want.rec.rtype);
				check_field("src_port", got.src, want.rec.src);
				check_field("dst_port", got.dst, want.rec.dst);
				check_field("seq_number", got.seq, want.rec.seq);
				check_field("ack_number", got.ack, want.rec.ack);
				check_field("header_bytes", got.hb, want.rec.hb);
				check_field("flag_bits", got.flags, want.rec.flags);
				check_field("window_size", got.window, want.rec.window);
				check_field("header_checksum", got.checksum, want.rec.checksum);
				check_field("option_kind", got.kind, want.rec.kind);
				check_field("option_value", got.value, want.rec.value);
				check_field("last_of_run", last, want.last);
			end
			checked++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [7:0]                  s_axis_tdata = '0;   // [7:0] seg_byte
	logic                        s_axis_tuser = 1'b0; // [0] start_of_segment
	logic                        s_axis_tlast = 1'b0; // end_of_segment
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	// [2:0] record_type .. [160:153] option_value, upper bits zero
	logic [OutDataBytes*8-1:0]   m_axis_tdata;
	logic                        m_axis_tlast;        // last_of_run

	tcp_header_option_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	tcp_record_scoreboard rec_board = new();

	logic [7:0] seg_bytes[$];  // segment under construction
	int         words_sent;
	int         segments;
	bit         quiet_stretch;  // no idling on either side while set
	int         stall_left;
	bit         long_stall_done;
	int         cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Input and output monitor in one process: the input side is noted before
	// the output side within the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				rec_board.note_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				rec_board.check_record(m_axis_tdata, m_axis_tlast);
		end
	end

	// Receiver: random back-pressure, plus one long hold once traffic is going
	// so the entry queue fills and s_axis_tready drops.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (!long_stall_done && rec_board.words >= STALL_AT_WORD) begin
			m_axis_tready <= 1'b0;
			stall_left = LONG_STALL;
			long_stall_done = 1'b1;
		end else begin
			m_axis_tready <= quiet_stretch || ($urandom_range(99) >= 15);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records owed", cycle_count,
					rec_board.pending());
			$display("tcp_header_option_parser_tb: FAIL");
			$finish;
		end
	end

	// Offer one word, with random idle cycles ahead of it; returns on the edge
	// where it is taken.
	task automatic send_word(input logic [7:0] b, input logic sos, input logic eos);
		while (!quiet_stretch && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= sos;
		s_axis_tlast <= eos;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
		quiet_stretch = (words_sent >= CALM_FROM && words_sent < CALM_TO);
	endtask

	task automatic send_segment(input bit mark_start, input bit mark_end);
		int i;
		for (i = 0; i < seg_bytes.size(); i++)
			send_word(seg_bytes[i], mark_start && i == 0,
					mark_end && i == seg_bytes.size() - 1);
		segments++;
	endtask

	// Mostly well-formed segments: random header, option list that fits the
	// data offset, a little payload. The rest are short offsets, garbage
	// options, bad lengths, cut-off segments and long payloads.
	function automatic void build_segment();
		int unsigned off, hb, pos, room, len, shape, cut, i;
		bit          garbage;
		seg_bytes.delete();
		off = ($urandom_range(99) < 12) ? $urandom_range(4) : $urandom_range(15, 5);
		hb = off * 4;
		for (i = 0; i < 20; i++)
			seg_bytes = {seg_bytes, 8'($urandom)};
		seg_bytes[12] = {off[3:0], seg_bytes[12][3:0]};

		garbage = ($urandom_range(99) < 15);
		pos = 20;
		while (pos < hb) begin
			room = hb - pos;
			if (garbage) begin
				seg_bytes = {seg_bytes, 8'($urandom)};
				pos++;
			end else if (room < 2 || $urandom_range(99) < 30) begin
				seg_bytes = {seg_bytes, 8'($urandom_range(1))};
				pos++;
			end else begin
				len = $urandom_range(room, 2);
				seg_bytes = {seg_bytes, 8'($urandom_range(255, 2))};
				// now and then a length that does not fit
				seg_bytes = {seg_bytes,
						(($urandom_range(19) == 0) ? 8'($urandom) : 8'(len))};
				for (i = 2; i < len; i++)
					seg_bytes = {seg_bytes, 8'($urandom)};
				pos += len;
			end
		end

		shape = $urandom_range(99);
		if (shape < 8) begin
			cut = $urandom_range(18, 1);           // ends inside the fixed header
		end else if (shape < 16 && hb > 20) begin
			cut = $urandom_range(hb - 1, 20);      // ends inside the options
		end else begin
			cut = seg_bytes.size();
			len = (shape < 22) ? $urandom_range(50, 20) : $urandom_range(4);
			for (i = 0; i < len; i++)
				seg_bytes = {seg_bytes, 8'($urandom)};
		end
		while (seg_bytes.size() > cut && shape < 16 && (shape < 8 || hb > 20))
			void'(seg_bytes.pop_back());
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone zero byte: start and end at once, truncated header
		seg_bytes = '{8'h00};
		send_segment(1'b1, 1'b1);
		// all-ones header ending at byte 19 with a 60-byte offset: header
		// record then outside record
		seg_bytes.delete();
		repeat (20) seg_bytes = {seg_bytes, 8'hFF};
		send_segment(1'b1, 1'b1);

		// random segments; a missing end mark makes the next start mark cut
		// in mid-segment, a missing start mark relies on the previous end
		while (words_sent < RANDOM_WORDS + 21) begin
			build_segment();
			send_segment($urandom_range(99) < 90, $urandom_range(99) < 92);
		end
		s_axis_tvalid <= 1'b0;

		while (rec_board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (rec_board.pending() != 0)
			rec_board.report($sformatf("%0d records never came", rec_board.pending()));

		$display("ran %0d bytes in %0d segments, checked %0d records",
				rec_board.words, segments, rec_board.checked);
		$display("headers %0d, option starts %0d, option bytes %0d, errors %0d/%0d/%0d/%0d",
				rec_board.seen_by_type[REC_HEADER], rec_board.seen_by_type[REC_OPT_START],
				rec_board.seen_by_type[REC_OPT_BYTE], rec_board.seen_by_type[REC_TRUNCATED],
				rec_board.seen_by_type[REC_OFF_SMALL], rec_board.seen_by_type[REC_OUTSIDE],
				rec_board.seen_by_type[REC_MALFORMED]);
		if (rec_board.errors == 0)
			$display("tcp_header_option_parser_tb: PASS");
		else
			$display("tcp_header_option_parser_tb: FAIL");
		$finish;
	end

endmodule
